// File: sv/pwrd_pkg.sv
// Package for the pulse-width response decoder: field widths, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package pwrd_pkg;

   localparam int MAX_SLOTS_DEF = 32;

   localparam int PERIOD_W   = 16;
   localparam int HIGH_W     = 16;
   localparam int WORD_W     = 32;
   localparam int MEAN_W     = 24;
   localparam int FRAC_W     = 8;   // fraction bits of mean_period
   localparam int RATIO_W    = 16;
   localparam int FRAME_W    = 6;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_FRAME_BITS    = 2'd0;
   localparam csr_idx_type CSR_ONE_MIN_RATIO = 2'd1;
   localparam csr_idx_type CSR_ONE_MAX_RATIO = 2'd2;

   localparam logic [FRAME_W-1:0] FRAME_BITS_RST    = 6'd21;
   localparam logic [RATIO_W-1:0] ONE_MIN_RATIO_RST = 16'd30583;
   localparam logic [RATIO_W-1:0] ONE_MAX_RATIO_RST = 16'd56798;

endpackage

// File: sv/pwrd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pwrd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pulse_width_response_decoder.sv
// Pulse-width response decoder top level: slot capture, period sum, shared
// serial divider and width-store scan. Uses pwrd_pkg and pwrd_ram.
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata: period_count, high_count
//  rsp     | out | rsp_tvalid/tready  | tdata: response_word, mean_period
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
//
//  A slot item is taken when the block is idle. The last slot of a frame
//  starts a frame-end pass with the input held off: a multiply step, three
//  serial divisions on one shared divider (skipped for one-slot frames), a
//  scan reading the width store and a step loading the output register,
//  which waits while that register is full. Reset is synchronous; the width
//  store is not cleared.

module pulse_width_response_decoder #(
   parameter int MAX_SLOTS = pwrd_pkg::MAX_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // [15:0] period_count, [31:16] high_count
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pwrd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [31:0] response_word, [55:32] mean_period
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pwrd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwrd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwrd_pkg::CSR_DATA_W-1:0]   csr_data
);

   import pwrd_pkg::*;

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int SUM_W  = PERIOD_W + SLOT_W;
   localparam int PROD_W = SUM_W + RATIO_W;
   localparam int DIV_W  = SUM_W + FRAC_W;
   localparam int CNT_W  = $clog2(DIV_W);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam logic [1:0] SEL_MEAN = 2'd0;
   localparam logic [1:0] SEL_LO   = 2'd1;
   localparam logic [1:0] SEL_HI   = 2'd2;

   // configuration
   logic [FRAME_W-1:0] frame_bits_ff;
   logic [RATIO_W-1:0] min_ratio_ff, max_ratio_ff;

   // control
   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0] count_ff, count_in;   // slots in frame minus one
   logic [1:0]        sel_ff, sel_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   // sum * ratio, already scaled down by 2^16
   logic [SUM_W-1:0]  prod_lo_ff, prod_lo_in, prod_hi_ff, prod_hi_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [SUM_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              issue_ff, issue_in;
   logic [SLOT_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rd_vld_ff, rd_vld_in, rd_last_ff, rd_last_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PERIOD_W-1:0] req_period;
   logic [HIGH_W-1:0]   req_high;
   logic                req_fire, rd_en, frame_end, hit;
   logic [SLOT_W:0]     slot_next, rem_shift, rem_diff;
   logic [HIGH_W-1:0]   rd_data;
   logic [DIV_W-1:0]    dividend;

   assign req_period = req_tdata[PERIOD_W-1:0];
   assign req_high   = req_tdata[PERIOD_W +: HIGH_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign slot_next = {1'b0, slot_ff} + 1'b1;
   assign frame_end = (FRAME_W'(slot_next) >= frame_bits_ff) ||
                      (slot_ff == SLOT_W'(MAX_SLOTS - 1));

   assign rd_en = (state_ff == ST_SCAN) && issue_ff;

   pwrd_ram #(
      .WIDTH (HIGH_W),
      .DEPTH (MAX_SLOTS)
   ) u_width_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (slot_ff),
      .wr_data (req_high),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // one restoring division step
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, count_ff};

   always_comb begin
      case (sel_ff)
         SEL_MEAN: dividend = {sum_ff, {FRAC_W{1'b0}}};
         SEL_LO:   dividend = DIV_W'(prod_lo_ff);
         default:  dividend = DIV_W'(prod_hi_ff);
      endcase
   end

   assign hit = ({{(SUM_W-HIGH_W){1'b0}}, rd_data} > lo_ff) &&
                ({{(SUM_W-HIGH_W){1'b0}}, rd_data} < hi_ff);

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      sel_in      = sel_ff;
      div_cnt_in  = div_cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      mean_in     = mean_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      word_in     = word_ff;
      issue_in    = issue_ff;
      rd_addr_in  = rd_addr_ff;
      rd_vld_in   = rd_en;
      rd_last_in  = rd_en && (rd_addr_ff == count_ff);
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (slot_ff != '0) begin
                  sum_in = sum_ff + SUM_W'(req_period);
               end
               if (frame_end) begin
                  count_in = slot_ff;
                  slot_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  slot_in = slot_next[SLOT_W-1:0];
               end
            end
         end
         ST_MUL: begin
            prod_lo_in = SUM_W'((PROD_W'(sum_ff) * PROD_W'(min_ratio_ff)) >> RATIO_W);
            prod_hi_in = SUM_W'((PROD_W'(sum_ff) * PROD_W'(max_ratio_ff)) >> RATIO_W);
            word_in    = '0;
            sel_in     = SEL_MEAN;
            rd_addr_in = '0;
            if (count_ff == '0) begin
               // one-slot frame: no average, empty window
               mean_in  = '0;
               lo_in    = '0;
               hi_in    = '0;
               issue_in = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            quo_in     = dividend;
            rem_in     = '0;
            div_cnt_in = CNT_W'(DIV_W - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!rem_diff[SLOT_W]) begin
               rem_in = rem_diff[SLOT_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[SLOT_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               case (sel_ff)
                  SEL_MEAN: mean_in = quo_in[MEAN_W-1:0];
                  SEL_LO:   lo_in   = quo_in[SUM_W-1:0];
                  default:  hi_in   = quo_in[SUM_W-1:0];
               endcase
               if (sel_ff == SEL_HI) begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               if (rd_addr_ff == count_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + 1'b1;
               end
            end
            // slot 0 enters first and ends up in the top used bit
            if (rd_vld_ff) begin
               word_in = {word_ff[WORD_W-2:0], hit};
               if (rd_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {mean_ff, word_ff};
               sum_in      = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         sum_ff        <= '0;
         issue_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         frame_bits_ff <= FRAME_BITS_RST;
         min_ratio_ff  <= ONE_MIN_RATIO_RST;
         max_ratio_ff  <= ONE_MAX_RATIO_RST;
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         sum_ff     <= sum_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_BITS:    frame_bits_ff <= csr_data[FRAME_W-1:0];
               CSR_ONE_MIN_RATIO: min_ratio_ff  <= csr_data[RATIO_W-1:0];
               CSR_ONE_MAX_RATIO: max_ratio_ff  <= csr_data[RATIO_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      sel_ff      <= sel_in;
      div_cnt_ff  <= div_cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      mean_ff     <= mean_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      word_ff     <= word_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: test/pwrd_frame_checker.sv
// Frame checker for the pulse-width response decoder: watches the slot,
// result and register channels, predicts each decoded frame and compares.
// Depends on pwrd_pkg.
`timescale 1ns / 1ps

module pwrd_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pwrd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pwrd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pwrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pwrd_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              error_count,
   output int                              frames_pending
);

   import pwrd_pkg::*;

   localparam int SUM_W = 21;

   typedef struct packed {
      logic [WORD_W-1:0] response_word;
      logic [MEAN_W-1:0] mean_period;
   } decoded_frame_type;

   decoded_frame_type decoded_frames_q[$];
   logic [HIGH_W-1:0] width_mem [MAX_SLOTS_DEF];
   logic [SUM_W-1:0]  period_acc;
   logic [FRAME_W-1:0] slot_no;
   logic [FRAME_W-1:0] frame_bits_cfg;
   logic [RATIO_W-1:0] min_ratio_cfg;
   logic [RATIO_W-1:0] max_ratio_cfg;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      error_count++;
   endtask

   // floor(sum * ratio / (count * 2^16)), exact
   function automatic logic [31:0] window_edge(input logic [SUM_W-1:0] sum,
                                               input logic [RATIO_W-1:0] ratio,
                                               input int cnt);
      longint unsigned num;
      longint unsigned den;
      if (cnt == 0) return '0;
      num = sum;
      num = num * ratio;
      den = cnt;
      den = den << 16;
      return 32'(num / den);
   endfunction

   task automatic decode_slot(input logic [PERIOD_W-1:0] period,
                              input logic [HIGH_W-1:0] high);
      int s;
      int n;
      int cnt;
      logic [31:0] lo;
      logic [31:0] hi;
      longint unsigned mean;
      decoded_frame_type fr;
      s = slot_no % MAX_SLOTS_DEF;
      width_mem[s] = high;
      if (s != 0) period_acc = period_acc + period;
      n = s + 1;
      if (n < frame_bits_cfg && n < MAX_SLOTS_DEF) begin
         slot_no = FRAME_W'(n);
         return;
      end
      cnt = n - 1;
      mean = period_acc;
      mean = (cnt != 0) ? (mean << FRAC_W) / cnt : 0;
      lo = window_edge(period_acc, min_ratio_cfg, cnt);
      hi = window_edge(period_acc, max_ratio_cfg, cnt);
      fr.response_word = '0;
      fr.mean_period   = MEAN_W'(mean);
      for (int j = 0; j < n; j++) begin
         if (width_mem[j] > lo && width_mem[j] < hi) fr.response_word[n-1-j] = 1'b1;
      end
      decoded_frames_q.push_back(fr);
      period_acc = '0;
      slot_no    = '0;
   endtask

   task automatic check_frame(input logic [RSP_DATA_W-1:0] data);
      decoded_frame_type fr;
      if (decoded_frames_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", data));
         return;
      end
      fr = decoded_frames_q.pop_front();
      if (data[WORD_W-1:0] !== fr.response_word)
         report_mismatch($sformatf("response_word got %h expected %h",
                                   data[WORD_W-1:0], fr.response_word));
      if (data[WORD_W +: MEAN_W] !== fr.mean_period)
         report_mismatch($sformatf("mean_period got %h expected %h",
                                   data[WORD_W +: MEAN_W], fr.mean_period));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decoded_frames_q.delete();
         period_acc     = '0;
         slot_no        = '0;
         frame_bits_cfg = FRAME_BITS_RST;
         min_ratio_cfg  = ONE_MIN_RATIO_RST;
         max_ratio_cfg  = ONE_MAX_RATIO_RST;
      end else begin
         if (req_tvalid && req_tready)
            decode_slot(req_tdata[PERIOD_W-1:0], req_tdata[PERIOD_W +: HIGH_W]);
         if (rsp_tvalid && rsp_tready) check_frame(rsp_tdata);
         // a register written at this edge applies from the next slot on
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_BITS:    frame_bits_cfg = csr_data[FRAME_W-1:0];
               CSR_ONE_MIN_RATIO: min_ratio_cfg  = csr_data[RATIO_W-1:0];
               CSR_ONE_MAX_RATIO: max_ratio_cfg  = csr_data[RATIO_W-1:0];
               default: ;
            endcase
         end
      end
      frames_pending = decoded_frames_q.size();
   end

endmodule

// File: test/tb_top.sv
// Testbench top for the pulse-width response decoder: clock, reset, slot and
// register stimulus, result-side stalls, watchdog and verdict.
// Depends on pwrd_pkg, pulse_width_response_decoder and pwrd_frame_checker.
`timescale 1ns / 1ps

module tb_top;
   import pwrd_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int SETTLE_CYCLES  = 300;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_PHASES     = 14;
   localparam int PHASE_ITEMS    = 38;
   localparam csr_idx_type CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int error_count;
   int frames_pending;
   int req_gap_pct   = 20;
   int rsp_stall_pct = 51;
   bit rsp_long_hold = 1'b0;
   int quiet_cycles  = 0;

   // stimulus-side copy of the registers, used to size frames and shape widths
   int fb_now;
   int min_now;
   int max_now;

   always #(CLK_PERIOD / 2) clock = ~clock;

   pulse_width_response_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pwrd_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .frames_pending (frames_pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_long_hold && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (!rsp_long_hold) held = 1'b0;
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // valid is left high after a handshake; callers lower it when they pause
   task automatic send_slot(input logic [PERIOD_W-1:0] period,
                            input logic [HIGH_W-1:0] high);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {high, period};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_frame_bits(input int fb);
      // upper data bits are don't-care for this register
      csr_write(CSR_FRAME_BITS, {10'($urandom()), 6'(fb)});
      fb_now = fb;
   endtask

   task automatic set_config(input int fb, input int lo, input int hi);
      set_frame_bits(fb);
      csr_write(CSR_ONE_MIN_RATIO, 16'(lo));
      csr_write(CSR_ONE_MAX_RATIO, 16'(hi));
      csr_valid <= 1'b0;
      min_now = lo;
      max_now = hi;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one frame; well-formed unless noisy: steady periods, widths near the one
   // and zero duty cycles, at or beside the window edges, or now and then random
   task automatic send_frame(input bit noisy, inout int sent);
      int n;
      longint base;
      longint p;
      longint h;
      longint lo_edge;
      longint hi_edge;
      n = (fb_now <= 1) ? 1 : ((fb_now > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : fb_now);
      case ($urandom_range(2))
         0:       base = $urandom_range(16, 400);
         1:       base = $urandom_range(400, 8000);
         default: base = $urandom_range(8000, 65535);
      endcase
      lo_edge = (base * min_now) >> 16;
      hi_edge = (base * max_now) >> 16;
      for (int k = 0; k < n; k++) begin
         if (noisy) begin
            p = $urandom_range(65535);
            h = $urandom_range(65535);
         end else begin
            p = base + $urandom_range(base / 16) - base / 32;
            case ($urandom_range(9))
               0, 1, 2, 3: h = (base * 2) / 3 + $urandom_range(base / 20) - base / 40;
               4, 5, 6:    h = (base * 3) / 10 + $urandom_range(base / 20) - base / 40;
               7:          h = lo_edge + $urandom_range(2) - 1;
               8:          h = hi_edge + $urandom_range(2) - 1;
               default:    h = $urandom_range(65535);
            endcase
         end
         if (p < 0) p = 0;
         if (p > 65535) p = 65535;
         if (h < 0) h = 0;
         if (h > 65535) h = 65535;
         send_slot(PERIOD_W'(p), HIGH_W'(h));
         sent++;
      end
   endtask

   initial begin : stimulus
      int fb;
      int lo;
      int hi;
      int tmp;
      int sent;
      fb_now  = FRAME_BITS_RST;
      min_now = ONE_MIN_RATIO_RST;
      max_now = ONE_MAX_RATIO_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes, four-slot frame
      set_config(4, ONE_MIN_RATIO_RST, ONE_MAX_RATIO_RST);
      send_slot(16'hFFFF, 16'h0000);
      send_slot(16'hFFFF, 16'hFFFF);
      send_slot(16'hFFFF, 16'hBFFF);
      send_slot(16'hFFFF, 16'h0000);
      wait_idle();
      // shortest regular frame, zero period sum: empty window
      set_config(2, ONE_MIN_RATIO_RST, ONE_MAX_RATIO_RST);
      send_slot(16'h1234, 16'h0000);
      send_slot(16'h0000, 16'h0000);
      wait_idle();
      // one-slot frames from frame_bits 1 and 0
      set_config(1, ONE_MIN_RATIO_RST, ONE_MAX_RATIO_RST);
      send_slot(16'h5555, 16'h5555);
      wait_idle();
      set_frame_bits(0);
      csr_valid <= 1'b0;
      send_slot(16'hAAAA, 16'hAAAA);
      wait_idle();
      // widths exactly on and just inside the window edges (500, 750)
      set_config(4, 32768, 49152);
      send_slot(16'd1000, 16'd500);
      send_slot(16'd1000, 16'd501);
      send_slot(16'd1000, 16'd750);
      send_slot(16'd1000, 16'd749);
      wait_idle();
      // frame length cut below the slots already stored
      set_config(6, ONE_MIN_RATIO_RST, ONE_MAX_RATIO_RST);
      for (int k = 0; k < 4; k++) send_slot(16'd2000 + 16'(k), 16'd1300);
      wait_idle();
      set_frame_bits(2);
      csr_valid <= 1'b0;
      send_slot(16'd2100, 16'd600);
      wait_idle();
      // unused register index is ignored
      csr_write(CSR_SPARE, 16'($urandom()));
      csr_valid <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       fb = MAX_SLOTS_DEF;
            1:       fb = 63;
            2:       fb = 2;
            3:       fb = 0;
            default: fb = ($urandom_range(3) == 0) ? $urandom_range(13, 63)
                                                   : $urandom_range(1, 12);
         endcase
         if (phase == 4) begin
            lo = 0;
            hi = 65535;
         end else if (phase == 5) begin
            lo = 65535;
            hi = 0;
         end else if ($urandom_range(2) == 0) begin
            lo = ONE_MIN_RATIO_RST;
            hi = ONE_MAX_RATIO_RST;
         end else begin
            lo = $urandom_range(65535);
            hi = $urandom_range(65535);
            if (lo > hi && $urandom_range(3) != 0) begin
               tmp = lo;
               lo  = hi;
               hi  = tmp;
            end
         end
         if (phase < 5) begin
            req_gap_pct   = 20;
            rsp_stall_pct = 51;
         end else if (phase < 10) begin
            req_gap_pct   = 51;
            rsp_stall_pct = 20;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         set_config(fb, lo, hi);
         // short frames behind a long result stall back up into the input
         if (phase == 2) rsp_long_hold = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) send_frame($urandom_range(9) == 0, sent);
         wait_idle();
         rsp_long_hold = 1'b0;
      end

      if (error_count == 0 && frames_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/pwrd_pkg.sv
sv/pwrd_ram.sv
sv/pulse_width_response_decoder.sv
test/pwrd_frame_checker.sv
test/tb_top.sv
